// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the face normal core, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`define TFN_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TFN_NEVER(lbl, cond, msg)
`define TFN_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and word types shared by the face normal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfn_pkg;

  localparam int unsigned COORD_WIDTH  = 24;
  localparam int unsigned NORMAL_WIDTH = 32;
  localparam int unsigned DIFF_WIDTH   = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH   = 2 * DIFF_WIDTH;
  localparam int unsigned CROSS_WIDTH  = PROD_WIDTH + 1;
  localparam int unsigned MAG_WIDTH    = PROD_WIDTH;
  localparam int unsigned HALF_WIDTH   = MAG_WIDTH / 2;
  localparam int unsigned SQ_WIDTH     = 2 * MAG_WIDTH;
  localparam int unsigned SUM_WIDTH    = SQ_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [NORMAL_WIDTH-1:0] normal_comp_t;
  typedef logic signed [CROSS_WIDTH-1:0]  cross_comp_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
  } tri_t;

  typedef struct packed {
    normal_comp_t normal_x;
    normal_comp_t normal_y;
    normal_comp_t normal_z;
    logic         degenerate;
  } normal_t;

  typedef struct packed {
    cross_comp_t x;
    cross_comp_t y;
    cross_comp_t z;
  } cross_t;

  typedef struct packed {
    logic [2:0][SQ_WIDTH-1:0] sq;
    logic [SUM_WIDTH-1:0]     sum;
    logic [2:0]               neg;
    logic                     degenerate;
  } len_t;

endpackage

// ===== rtl/core/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors and their cross product, three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tfn_pkg::tri_t   tri_i,
  output logic            valid_o,
  output tfn_pkg::cross_t cross_o
);
  import tfn_pkg::*;

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  diff_t  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  prod_t  p_q [6];
  cross_t cross_q;
  logic   v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // u = b - a, v = c - b
      ux_q <= DIFF_WIDTH'(tri_i.vertex_b_x) - DIFF_WIDTH'(tri_i.vertex_a_x);
      uy_q <= DIFF_WIDTH'(tri_i.vertex_b_y) - DIFF_WIDTH'(tri_i.vertex_a_y);
      uz_q <= DIFF_WIDTH'(tri_i.vertex_b_z) - DIFF_WIDTH'(tri_i.vertex_a_z);
      vx_q <= DIFF_WIDTH'(tri_i.vertex_c_x) - DIFF_WIDTH'(tri_i.vertex_b_x);
      vy_q <= DIFF_WIDTH'(tri_i.vertex_c_y) - DIFF_WIDTH'(tri_i.vertex_b_y);
      vz_q <= DIFF_WIDTH'(tri_i.vertex_c_z) - DIFF_WIDTH'(tri_i.vertex_b_z);
      p_q[0] <= uy_q * vz_q;
      p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q;
      p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q;
      p_q[5] <= uy_q * vx_q;
      cross_q.x <= CROSS_WIDTH'(p_q[0]) - CROSS_WIDTH'(p_q[1]);
      cross_q.y <= CROSS_WIDTH'(p_q[2]) - CROSS_WIDTH'(p_q[3]);
      cross_q.z <= CROSS_WIDTH'(p_q[4]) - CROSS_WIDTH'(p_q[5]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign cross_o = cross_q;

endmodule

// ===== rtl/core/tfn_square.sv =====
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the cross components in partial products, and their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_square (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tfn_pkg::cross_t cross_i,
  output logic            valid_o,
  output tfn_pkg::len_t   len_o
);
  import tfn_pkg::*;

  cross_comp_t              c_in [3];
  logic [MAG_WIDTH-1:0]     mag_d [3];
  logic [MAG_WIDTH-1:0]     mag_q [3];
  logic [MAG_WIDTH-1:0]     hh_q [3];
  logic [MAG_WIDTH-1:0]     hl_q [3];
  logic [MAG_WIDTH-1:0]     ll_q [3];
  logic [2:0][SQ_WIDTH-1:0] sq_q;
  logic [2:0]               neg_a_q, neg_b_q, neg_c_q;
  logic                     zero_a_q, zero_b_q, zero_c_q;
  len_t                     len_q;
  logic [3:0]               vld_q;

  assign c_in[0] = cross_i.x;
  assign c_in[1] = cross_i.y;
  assign c_in[2] = cross_i.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = c_in[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-c_in[i]) : MAG_WIDTH'(c_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]   <= mag_d[i];
        neg_a_q[i] <= c_in[i][CROSS_WIDTH-1];
        hh_q[i] <= mag_q[i][MAG_WIDTH-1:HALF_WIDTH] * mag_q[i][MAG_WIDTH-1:HALF_WIDTH];
        hl_q[i] <= mag_q[i][MAG_WIDTH-1:HALF_WIDTH] * mag_q[i][HALF_WIDTH-1:0];
        ll_q[i] <= mag_q[i][HALF_WIDTH-1:0] * mag_q[i][HALF_WIDTH-1:0];
        sq_q[i] <= (SQ_WIDTH'(hh_q[i]) << (2 * HALF_WIDTH))
                 + (SQ_WIDTH'(hl_q[i]) << (HALF_WIDTH + 1))
                 + SQ_WIDTH'(ll_q[i]);
      end
      zero_a_q <= (cross_i == '0);
      neg_b_q  <= neg_a_q;
      zero_b_q <= zero_a_q;
      neg_c_q  <= neg_b_q;
      zero_c_q <= zero_b_q;
      len_q.sq  <= sq_q;
      len_q.sum <= SUM_WIDTH'(sq_q[0]) + SUM_WIDTH'(sq_q[1]) + SUM_WIDTH'(sq_q[2]);
      len_q.neg <= neg_c_q;
      len_q.degenerate <= zero_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign len_o   = len_q;

endmodule

// ===== rtl/core/tfn_unit.sv =====
// ----------------------------------------------------------------------------
// tfn_unit
// One normal component: restoring divide of c^2 * 2^(2F) by the squared
// length, then a restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_unit #(
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [tfn_pkg::SQ_WIDTH-1:0]   sq_i,
  input  logic [tfn_pkg::SUM_WIDTH-1:0]  sum_i,
  input  logic                           neg_i,
  output logic [NORMAL_FRAC_BITS:0]      root_o,
  output logic                           neg_o
);
  import tfn_pkg::*;

  localparam int unsigned QW = 2 * NORMAL_FRAC_BITS + 1;
  localparam int unsigned RB = NORMAL_FRAC_BITS + 1;
  localparam int unsigned RW = NORMAL_FRAC_BITS + 2;
  localparam int unsigned TW = RW + 2;

  logic [SUM_WIDTH-1:0] rem_q [QW];
  logic [SUM_WIDTH-1:0] div_q [QW];
  logic [QW-1:0]        quo_q [QW];
  logic [QW-1:0]        dneg_q;

  logic [RW-1:0]        srem_q [RB];
  logic [RB-1:0]        root_q [RB];
  logic [QW-1:0]        val_q  [RB];
  logic [RB-1:0]        sneg_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [SUM_WIDTH-1:0] rem_in, div_in;
    logic [QW-1:0]        quo_in;
    logic                 bit_in, neg_in, ge;
    logic [SUM_WIDTH:0]   trial, diff;

    if (k == 0) begin : g_head
      assign rem_in = SUM_WIDTH'(sq_i >> 1);
      assign bit_in = sq_i[0];
      assign quo_in = '0;
      assign div_in = sum_i;
      assign neg_in = neg_i;
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign bit_in = 1'b0;
      assign quo_in = quo_q[k-1];
      assign div_in = div_q[k-1];
      assign neg_in = dneg_q[k-1];
    end

    assign trial = {rem_in, bit_in};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = (trial >= {1'b0, div_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[SUM_WIDTH-1:0] : trial[SUM_WIDTH-1:0];
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        div_q[k]  <= div_in;
        dneg_q[k] <= neg_in;
      end
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_root
    logic [RW-1:0]   rem_in;
    logic [RB-1:0]   root_in;
    logic [QW-1:0]   val_in;
    logic            neg_in, ge;
    logic [QW:0]     padded;
    logic [TW-1:0]   cur, trial, diff;

    if (j == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = quo_q[QW-1];
      assign neg_in  = dneg_q[QW-1];
    end else begin : g_body
      assign rem_in  = srem_q[j-1];
      assign root_in = root_q[j-1];
      assign val_in  = val_q[j-1];
      assign neg_in  = sneg_q[j-1];
    end

    assign padded = {1'b0, val_in};
    assign cur    = {rem_in, padded[2*(RB-1-j) +: 2]};
    assign trial  = TW'({root_in, 2'b01});
    assign diff   = cur - trial;
    assign ge     = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[j] <= ge ? diff[RW-1:0] : cur[RW-1:0];
        root_q[j] <= {root_in[RB-2:0], ge};
        val_q[j]  <= val_in;
        sneg_q[j] <= neg_in;
      end
    end
  end

  assign root_o = root_q[RB-1];
  assign neg_o  = sneg_q[RB-1];

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle from its three vertices.
//
//   channel | handshake                  | word
//   in      | in_valid_i / in_ready_o    | in_data_i  (tri_t)
//   out     | out_valid_o / out_ready_i  | out_data_o (normal_t)
//
// one word per cycle while no output word is held
// the divide (2F+1 stages) and root (F+1 stages) produce one result bit per stage
// no state is kept between words; reset only clears the valid bits
// a held output word freezes the whole pipeline, nothing is lost or repeated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_face_normal #(
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tfn_pkg::tri_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tfn_pkg::normal_t out_data_o
);
  import tfn_pkg::*;

  localparam int unsigned UNIT_LAT = 3 * NORMAL_FRAC_BITS + 2;
  localparam int signed   UNIT_ONE = 1 << NORMAL_FRAC_BITS;

  logic                           en;
  logic                           cross_valid, len_valid;
  cross_t                         cross_vec;
  len_t                           len;
  logic [2:0][NORMAL_FRAC_BITS:0] root;
  logic [2:0]                     neg;
  logic [UNIT_LAT-1:0]            vld_line_q, deg_line_q;
  normal_comp_t                   comp [3];
  normal_t                        out_d, out_q;
  logic                           out_valid_q;
  logic                           out_zero, out_big;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tri_i   (in_data_i),
    .valid_o (cross_valid),
    .cross_o (cross_vec)
  );

  tfn_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cross_valid),
    .cross_i (cross_vec),
    .valid_o (len_valid),
    .len_o   (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_unit
    tfn_unit #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_unit (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (len.sq[i]),
      .sum_i  (len.sum),
      .neg_i  (len.neg[i]),
      .root_o (root[i]),
      .neg_o  (neg[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_line_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_line_q  <= {vld_line_q[UNIT_LAT-2:0], len_valid};
      out_valid_q <= vld_line_q[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_line_q <= {deg_line_q[UNIT_LAT-2:0], len.degenerate};
      out_q      <= out_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = normal_comp_t'(root[i]);
      if (neg[i]) begin
        comp[i] = -comp[i];
      end
      if (deg_line_q[UNIT_LAT-1]) begin
        comp[i] = '0;
      end
    end
    out_d.normal_x   = comp[0];
    out_d.normal_y   = comp[1];
    out_d.normal_z   = comp[2];
    out_d.degenerate = deg_line_q[UNIT_LAT-1];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_zero = (out_data_o.normal_x == '0) && (out_data_o.normal_y == '0) &&
                    (out_data_o.normal_z == '0);
  assign out_big  = (out_data_o.normal_x > UNIT_ONE) || (out_data_o.normal_x < -UNIT_ONE);

  `TFN_IMPLIES(a_degen_zero, out_valid_o && out_data_o.degenerate, out_zero, "nonzero degenerate")
  `TFN_NEVER(a_lost_normal, out_valid_o && !out_data_o.degenerate && out_zero, "zero normal")
  `TFN_NEVER(a_bound_x, out_valid_o && out_big, "normal x beyond unit length")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the triangle face normal core against an exact integer predictor.
// Triangles are sent on the input channel and each accepted one is predicted;
// every output word is compared field by field in order. Directed extremes
// and degenerate cases come first, then random triangles under three
// back-pressure profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class normal_scoreboard;
  tfn_pkg::normal_t expected_q[$];
  int mismatches;
  int checked;
  int degenerate_seen;

  function tfn_pkg::normal_comp_t unit_component(longint n, logic [191:0] sum_sq);
    logic [191:0] mag;
    logic [191:0] target;
    logic [191:0] prod;
    logic [63:0]  root;
    logic [63:0]  cand;
    root = 0;
    mag = (n < 0) ? 192'(-n) : 192'(n);
    target = (mag * mag) << 60;
    for (int k = 30; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      prod = 192'(cand) * 192'(cand) * sum_sq;
      if (prod <= target) root = cand;
    end
    return (n < 0) ? -root[31:0] : root[31:0];
  endfunction

  function tfn_pkg::normal_t face_normal(tfn_pkg::tri_t t);
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [191:0] sum_sq;
    tfn_pkg::normal_t r;
    ux = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
    uy = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
    uz = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
    vx = longint'(t.vertex_c_x) - longint'(t.vertex_b_x);
    vy = longint'(t.vertex_c_y) - longint'(t.vertex_b_y);
    vz = longint'(t.vertex_c_z) - longint'(t.vertex_b_z);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    r = '0;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum_sq = 192'(nx < 0 ? -nx : nx) * 192'(nx < 0 ? -nx : nx)
           + 192'(ny < 0 ? -ny : ny) * 192'(ny < 0 ? -ny : ny)
           + 192'(nz < 0 ? -nz : nz) * 192'(nz < 0 ? -nz : nz);
    r.normal_x = unit_component(nx, sum_sq);
    r.normal_y = unit_component(ny, sum_sq);
    r.normal_z = unit_component(nz, sum_sq);
    return r;
  endfunction

  function void note_triangle(tfn_pkg::tri_t t);
    expected_q = {expected_q, face_normal(t)};
  endfunction

  function void check_normal(tfn_pkg::normal_t got);
    tfn_pkg::normal_t exp_w;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word %h", got);
      return;
    end
    exp_w = expected_q.pop_front();
    checked++;
    if (exp_w.degenerate) degenerate_seen++;
    if (got.normal_x !== exp_w.normal_x || got.normal_y !== exp_w.normal_y ||
        got.normal_z !== exp_w.normal_z || got.degenerate !== exp_w.degenerate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: expected x=%0d y=%0d z=%0d deg=%0b, got x=%0d y=%0d z=%0d deg=%0b",
                 checked, exp_w.normal_x, exp_w.normal_y, exp_w.normal_z, exp_w.degenerate,
                 got.normal_x, got.normal_y, got.normal_z, got.degenerate);
    end
  endfunction
endclass

module testbench;
  import tfn_pkg::*;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  tri_t    in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  normal_t out_data_o;

  normal_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int sent;
  tri_t directed[$];

  triangle_face_normal uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

  // output side: ready driven at the rising edge, words taken at the falling edge
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_normal(out_data_o);
  end

  function automatic coord_t rand_coord(int bits);
    int unsigned lim;
    lim = 1 << (bits - 1);
    return coord_t'(int'($urandom_range(2 * lim - 1)) - int'(lim));
  endfunction

  function automatic tri_t make_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx,
                                    coord_t by, coord_t bz, coord_t cx, coord_t cy,
                                    coord_t cz);
    tri_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return t;
  endfunction

  function automatic tri_t full_tri();
    return make_tri(rand_coord(24), rand_coord(24), rand_coord(24),
                    rand_coord(24), rand_coord(24), rand_coord(24),
                    rand_coord(24), rand_coord(24), rand_coord(24));
  endfunction

  function automatic void add_directed(tri_t t);
    directed = {directed, t};
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int kind;
    int bits;
    coord_t dx, dy, dz;
    int j, k;
    kind = $urandom_range(99);
    if (kind < 40) begin
      t = full_tri();
    end else if (kind < 70) begin
      bits = $urandom_range(2, 16);
      t = make_tri(rand_coord(bits), rand_coord(bits), rand_coord(bits),
                   rand_coord(bits), rand_coord(bits), rand_coord(bits),
                   rand_coord(bits), rand_coord(bits), rand_coord(bits));
    end else if (kind < 85) begin
      // collinear vertices
      t.vertex_a_x = rand_coord(21);
      t.vertex_a_y = rand_coord(21);
      t.vertex_a_z = rand_coord(21);
      dx = rand_coord(11);
      dy = rand_coord(11);
      dz = rand_coord(11);
      j = $urandom_range(200) - 100;
      k = $urandom_range(200) - 100;
      t.vertex_b_x = t.vertex_a_x + coord_t'(j * dx);
      t.vertex_b_y = t.vertex_a_y + coord_t'(j * dy);
      t.vertex_b_z = t.vertex_a_z + coord_t'(j * dz);
      t.vertex_c_x = t.vertex_a_x + coord_t'(k * dx);
      t.vertex_c_y = t.vertex_a_y + coord_t'(k * dy);
      t.vertex_c_z = t.vertex_a_z + coord_t'(k * dz);
    end else begin
      // two vertices shared
      t = full_tri();
      case ($urandom_range(2))
        0: {t.vertex_b_x, t.vertex_b_y, t.vertex_b_z} =
             {t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
        1: {t.vertex_c_x, t.vertex_c_y, t.vertex_c_z} =
             {t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
        default: {t.vertex_c_x, t.vertex_c_y, t.vertex_c_z} =
             {t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
      endcase
    end
    return t;
  endfunction

  task automatic send_triangle(tri_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(negedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    sb.note_triangle(t);
    sent++;
    @(posedge clk_i);
  endtask

  localparam coord_t CMAX = 24'sh7fffff;
  localparam coord_t CMIN = -24'sh800000;

  initial begin
    sb = new();
    sent = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 62;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_directed('0);
    add_directed(make_tri(0, 0, 0, 24'sh10000, 0, 0, 24'sh10000, 24'sh10000, 0));
    add_directed(make_tri(0, 0, 0, 0, 0, 24'sh10000, 0, 24'sh10000, 24'sh10000));
    add_directed(make_tri(0, 0, 0, 0, 24'sh10000, 0, 24'sh10000, 24'sh10000, 0));
    add_directed(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN));
    add_directed(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
    add_directed(make_tri(CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX));
    add_directed(make_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
    add_directed(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    add_directed(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    add_directed(make_tri(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX));
    add_directed(make_tri(1, 2, 3, 1, 2, 3, 7, -5, 9));
    add_directed(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    add_directed(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_directed(make_tri(0, 0, 0, -1, 0, 0, 0, -1, 0));
    add_directed(make_tri(0, 0, 0, 1, 1, 0, 1, 2, 1));
    add_directed(make_tri(-1, -1, -1, 0, -1, -1, 0, 0, -1));
    add_directed(make_tri(0, 0, 0, CMAX, 0, 0, CMAX, 1, 0));
    add_directed(make_tri(0, 0, 0, CMAX, 1, 0, CMAX, 1, 1));
    add_directed(make_tri(0, 0, 0, 3, 4, 0, 3, 4, 5));
    foreach (directed[i]) send_triangle(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 62 : 0;
      rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 27 : 0;
      repeat (560) send_triangle(random_tri());
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("sent %0d triangles, checked %0d normals, %0d of them degenerate",
             sent, sb.checked, sb.degenerate_seen);
    $display("mismatching words: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
